// ----- src/math_markup_tokenizer_macros.svh -----
// Assertion macros shared by the tokenizer RTL.
`ifndef MATH_MARKUP_TOKENIZER_MACROS_SVH
`define MATH_MARKUP_TOKENIZER_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define MMT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tokenizer assertion failed");

// Check that a condition never holds.
`define MMT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("tokenizer forbidden condition seen");

`else

`define MMT_ASSERT(label, prop)
`define MMT_NEVER(label, expr)

`endif

`endif

// ----- src/mmt_pkg.sv -----
// Shared types, token kind codes, byte codes and the punctuation table.
`timescale 1ns / 1ps

package mmt_pkg;

    localparam int CHUNK_BYTES = 8;
    localparam int MAX_RESULTS = 5;
    localparam int POS_OUT_W   = 16;

    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam logic [5:0] K_NUMBER    = 6'd0;
    localparam logic [5:0] K_DECIMAL   = 6'd1;
    localparam logic [5:0] K_EQUALS    = 6'd2;
    localparam logic [5:0] K_LPAREN    = 6'd3;
    localparam logic [5:0] K_RPAREN    = 6'd4;
    localparam logic [5:0] K_LBRACE    = 6'd5;
    localparam logic [5:0] K_PLUS      = 6'd6;
    localparam logic [5:0] K_MINUS     = 6'd7;
    localparam logic [5:0] K_STAR      = 6'd8;
    localparam logic [5:0] K_SLASH     = 6'd9;
    localparam logic [5:0] K_COMMA     = 6'd10;
    localparam logic [5:0] K_CARET     = 6'd11;
    localparam logic [5:0] K_COLON     = 6'd12;
    localparam logic [5:0] K_SEMICOLON = 6'd13;
    localparam logic [5:0] K_PIPE      = 6'd14;
    localparam logic [5:0] K_LESS      = 6'd15;
    localparam logic [5:0] K_GREATER   = 6'd16;
    localparam logic [5:0] K_PRIME     = 6'd17;
    localparam logic [5:0] K_DOLLAR    = 6'd18;
    localparam logic [5:0] K_PERCENT   = 6'd19;
    localparam logic [5:0] K_TILDE     = 6'd20;
    localparam logic [5:0] K_HASH      = 6'd21;
    localparam logic [5:0] K_UNDERSCR  = 6'd22;
    localparam logic [5:0] K_LBRACK    = 6'd23;
    localparam logic [5:0] K_RBRACK    = 6'd24;
    localparam logic [5:0] K_DOT       = 6'd25;
    localparam logic [5:0] K_RBRACE    = 6'd26;
    localparam logic [5:0] K_DBL       = 6'd27;
    localparam logic [5:0] K_AMP       = 6'd28;
    localparam logic [5:0] K_IDENT     = 6'd29;
    localparam logic [5:0] K_COMMAND   = 6'd30;
    localparam logic [5:0] K_EOF       = 6'd31;
    localparam logic [5:0] K_NONE      = 6'd32;

    // What one accepted word asks of the result side.
    typedef struct packed {
        logic                 flush;   // a stored token leaves
        logic [4:0]           fkind;
        logic [POS_OUT_W-1:0] line;
        logic [POS_OUT_W-1:0] fcol;
        logic                 trunc;
        logic                 xtra;    // one extra result after the token
        logic [4:0]           xkind;
        logic [POS_OUT_W-1:0] xcol;
        logic                 xtext;   // extra result carries the current byte
        logic                 wr_en;   // byte goes into the buffer
    } mmt_plan_t;

    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            "=":     k = K_EQUALS;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "{":     k = K_LBRACE;
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            ",":     k = K_COMMA;
            "^":     k = K_CARET;
            ":":     k = K_COLON;
            ";":     k = K_SEMICOLON;
            "|":     k = K_PIPE;
            "<":     k = K_LESS;
            ">":     k = K_GREATER;
            "'":     k = K_PRIME;
            "$":     k = K_DOLLAR;
            "%":     k = K_PERCENT;
            "~":     k = K_TILDE;
            "#":     k = K_HASH;
            "_":     k = K_UNDERSCR;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            "}":     k = K_RBRACE;
            "&":     k = K_AMP;
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

// ----- src/mmt_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module mmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/mmt_lex.sv -----
// Byte classifier and lexer state: decides flushes, extra results and buffer writes.
`timescale 1ns / 1ps
`include "math_markup_tokenizer_macros.svh"

module mmt_lex import mmt_pkg::*; #(
    parameter int MAX_TOKEN_BYTES = 32,
    parameter int POSITION_BITS = 16,
    localparam int BCW = $clog2(MAX_TOKEN_BYTES + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic           op,
    input  logic [7:0]     ch,
    input  logic [7:0]     next_ch,
    input  logic           has_next,
    output mmt_plan_t      plan,
    output logic [BCW-1:0] fbytes,
    output logic [BCW-1:0] wr_idx
);

    localparam int PB = POSITION_BITS;

    logic           cm_reg, cm_next;
    logic [5:0]     kind_reg, kind_next;
    logic [BCW-1:0] bc_reg, bc_next;
    logic           ovf_reg, ovf_next;
    logic [PB-1:0]  line_reg, line_next;
    logic [PB-1:0]  col_reg, col_next;
    logic [PB-1:0]  tsc_reg, tsc_next;
    logic           skip_reg, skip_next;

    logic           is_dig, is_let, is_dot, is_bs, is_sp, is_nl, is_punct, is_ident;
    logic           nxt_dig, dbl, keep_cmd, dec_cont, new_tok, tok1, txt;
    logic           flush_any, app, wr_ok;
    logic [5:0]     pk, last_k, cur_k;
    logic [BCW-1:0] bc_eff;
    logic           ovf_eff;
    logic [PB:0]    col_p1, col_p2;
    logic [PB-1:0]  col_i1, col_i2;

    always_comb
    begin
        pk       = punct_kind(ch);
        is_dig   = ch inside {["0":"9"]};
        is_let   = ch inside {["a":"z"], ["A":"Z"]};
        is_dot   = (ch == CH_DOT);
        is_bs    = (ch == CH_BSLASH);
        is_sp    = ch inside {CH_SPACE, CH_TAB};
        is_nl    = (ch == CH_NL);
        is_punct = (pk != K_IDENT);
        is_ident = !is_dig && !is_dot && !is_bs && !is_sp && !is_nl && !is_punct;
        nxt_dig  = has_next && (next_ch inside {["0":"9"]});
        dbl      = is_bs && has_next && (next_ch == CH_BSLASH);
        txt      = (op == OP_TEXT) && !skip_reg;

        // A command ends on any non-letter; the byte is then lexed from scratch.
        last_k   = cm_reg ? K_NONE : kind_reg;
        keep_cmd = cm_reg && is_let;
        dec_cont = !cm_reg && is_dot && (kind_reg == K_NUMBER) && nxt_dig;
        new_tok  = !keep_cmd && (is_dig || is_ident);
        cur_k    = is_dig ? ((last_k == K_DECIMAL) ? K_DECIMAL : K_NUMBER) : K_IDENT;
        tok1     = !keep_cmd && (is_punct || (is_dot && !dec_cont));

        if (op == OP_END)
        begin
            flush_any = 1'b1;
        end
        else if (skip_reg)
        begin
            flush_any = 1'b0;
        end
        else
        begin
            flush_any = !(keep_cmd || dec_cont || (new_tok && (cur_k == last_k)));
        end

        bc_eff  = flush_any ? '0 : bc_reg;
        ovf_eff = flush_any ? 1'b0 : ovf_reg;
        app     = txt && (keep_cmd || dec_cont || new_tok);
        wr_ok   = app && (bc_eff < BCW'(MAX_TOKEN_BYTES));

        col_p1 = {1'b0, col_reg} + (PB + 1)'(1);
        col_p2 = {1'b0, col_reg} + (PB + 1)'(2);
        col_i1 = col_p1[PB] ? '1 : col_p1[PB-1:0];
        col_i2 = col_p2[PB] ? '1 : col_p2[PB-1:0];

        plan.flush = flush_any && (bc_reg != '0);
        plan.fkind = kind_reg[4:0];
        plan.line  = POS_OUT_W'(line_reg);
        plan.fcol  = POS_OUT_W'(tsc_reg);
        plan.trunc = ovf_reg;
        plan.xtra  = (op == OP_END) || (txt && (dbl || tok1));
        if (op == OP_END)
        begin
            plan.xkind = K_EOF[4:0];
        end
        else if (dbl)
        begin
            plan.xkind = K_DBL[4:0];
        end
        else if (is_dot)
        begin
            plan.xkind = K_DOT[4:0];
        end
        else
        begin
            plan.xkind = pk[4:0];
        end
        plan.xcol  = POS_OUT_W'(col_reg);
        plan.xtext = (op == OP_TEXT) && tok1;
        plan.wr_en = wr_ok;

        fbytes = bc_reg;
        wr_idx = bc_eff;

        cm_next   = cm_reg;
        kind_next = kind_reg;
        bc_next   = bc_reg;
        ovf_next  = ovf_reg;
        line_next = line_reg;
        col_next  = col_reg;
        tsc_next  = tsc_reg;
        skip_next = skip_reg;

        if (op == OP_END)
        begin
            cm_next   = 1'b0;
            kind_next = K_NONE;
            bc_next   = '0;
            ovf_next  = 1'b0;
            line_next = PB'(1);
            col_next  = PB'(1);
            tsc_next  = PB'(1);
            skip_next = 1'b0;
        end
        else if (skip_reg)
        begin
            skip_next = 1'b0;
        end
        else
        begin
            cm_next  = keep_cmd || (is_bs && !dbl);
            bc_next  = wr_ok ? (bc_eff + BCW'(1)) : bc_eff;
            ovf_next = ovf_eff || (app && !wr_ok);
            skip_next = dbl;

            if (keep_cmd || (is_bs && !dbl))
            begin
                kind_next = K_COMMAND;
            end
            else if (dec_cont)
            begin
                kind_next = K_DECIMAL;
            end
            else if (new_tok)
            begin
                kind_next = cur_k;
            end
            else
            begin
                kind_next = K_NONE;
            end

            if ((new_tok && (bc_eff == '0)) || tok1 || (is_bs && !dbl))
            begin
                tsc_next = col_reg;
            end

            if (is_nl)
            begin
                col_next = PB'(1);
                if (line_reg != '1)
                begin
                    line_next = line_reg + PB'(1);
                end
            end
            else if (dbl)
            begin
                col_next = col_i2;
            end
            else
            begin
                col_next = col_i1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cm_reg   <= 1'b0;
            kind_reg <= K_NONE;
            bc_reg   <= '0;
            ovf_reg  <= 1'b0;
            line_reg <= PB'(1);
            col_reg  <= PB'(1);
            tsc_reg  <= PB'(1);
            skip_reg <= 1'b0;
        end
        else if (accept)
        begin
            cm_reg   <= cm_next;
            kind_reg <= kind_next;
            bc_reg   <= bc_next;
            ovf_reg  <= ovf_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            tsc_reg  <= tsc_next;
            skip_reg <= skip_next;
        end
    end

    `MMT_ASSERT(a_ovf_full, ovf_reg |-> (bc_reg == BCW'(MAX_TOKEN_BYTES)))
    `MMT_ASSERT(a_cmd_kind, cm_reg |-> (kind_reg == K_COMMAND))
    `MMT_ASSERT(a_end_clears, (accept && (op == OP_END)) |=> ((bc_reg == '0) && !cm_reg && !skip_reg))

endmodule

// ----- src/math_markup_tokenizer.sv -----
// Math markup tokenizer top level: token buffer RAM, chunk sequencer and output register.
// Bytes enter one word per cycle while in_stall is low, with a one-byte lookahead; a word
// that emits no result is taken without a stall. Token text sits in eight byte-wide RAM banks,
// so a whole 8-byte chunk comes out of one read. A word that emits results holds in_stall
// until its last result is loaded into the output register; when stored text leaves, the
// first chunk also waits for the registered RAM read, and output stalls add to the wait.
// At most five results leave per word. No clearing pass runs after reset.
`timescale 1ns / 1ps
`include "math_markup_tokenizer_macros.svh"

module math_markup_tokenizer import mmt_pkg::*; #(
    parameter int MAX_TOKEN_BYTES = 32,
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  ch,
    input  logic [7:0]  next_ch,
    input  logic        has_next,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  kind,
    output logic [15:0] line,
    output logic [15:0] column,
    output logic [63:0] text_chunk,
    output logic [3:0]  chunk_bytes,
    output logic        final_chunk,
    output logic        truncated,
    output logic        last
);

    localparam int ROWS = (MAX_TOKEN_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
    localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BCW  = $clog2(MAX_TOKEN_BYTES + 1);
    localparam int CNW  = $clog2(ROWS + 1);

    mmt_plan_t      plan;
    logic [BCW-1:0] fbytes, wr_idx;
    logic           accept, job_start;

    logic           busy_reg;
    logic [4:0]     job_kind_reg;
    logic [15:0]    job_line_reg, job_col_reg;
    logic           job_trunc_reg;
    logic [BCW-1:0] job_bc_reg;
    logic [CNW-1:0] job_nch_reg, job_lim_reg, iss_reg, rd_idx_reg;
    logic           rdv_reg;
    logic           x_reg;
    logic [4:0]     x_kind_reg;
    logic [15:0]    x_col_reg;
    logic           x_text_reg;
    logic [7:0]     x_byte_reg;
    logic           pw_reg;
    logic [7:0]     pw_byte_reg;

    logic           out_valid_reg;
    logic [4:0]     kind_reg;
    logic [15:0]    line_reg, column_reg;
    logic [63:0]    chunk_reg;
    logic [3:0]     bytes_reg;
    logic           final_reg, trunc_reg, last_reg;

    logic [BCW:0]   bc_plus;
    logic [CNW-1:0] nch_in, lim_in;
    logic           x_in;
    logic           out_free, load_chunk, load_extra, issue, chunk_last, done;
    logic           wr_go;
    logic [RAW-1:0] waddr;
    logic [2:0]     wr_bank;
    logic [7:0]     wdata;
    logic [7:0]     rd_bank [CHUNK_BYTES];
    logic [BCW-1:0] rem;
    logic [3:0]     nb;
    logic [63:0]    chunk_val;

    assign accept    = in_valid && !busy_reg;
    assign in_stall  = busy_reg;
    assign job_start = accept && (plan.flush || plan.xtra);

    mmt_lex #(
        .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES),
        .POSITION_BITS(POSITION_BITS)
    ) u_lex (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .op(op),
        .ch(ch),
        .next_ch(next_ch),
        .has_next(has_next),
        .plan(plan),
        .fbytes(fbytes),
        .wr_idx(wr_idx)
    );

    always_comb
    begin
        bc_plus = {1'b0, (plan.flush ? fbytes : BCW'(0))} + (BCW + 1)'(CHUNK_BYTES - 1);
        nch_in  = CNW'(bc_plus >> 3);
        lim_in  = (32'(nch_in) > MAX_RESULTS) ? CNW'(MAX_RESULTS) : nch_in;
        x_in    = plan.xtra && (32'(nch_in) < MAX_RESULTS);
    end

    // Read pipeline: issue a row, hold its data until the output register takes it.
    assign out_free   = !out_valid_reg || !out_stall;
    assign load_chunk = rdv_reg && out_free;
    assign issue      = busy_reg && (iss_reg < job_lim_reg) && (!rdv_reg || load_chunk);
    assign load_extra = busy_reg && x_reg && !rdv_reg && (iss_reg == job_lim_reg) && out_free;
    assign chunk_last = (rd_idx_reg == (job_lim_reg - CNW'(1)));
    assign done       = (load_chunk && chunk_last && !x_reg) || load_extra;

    // A byte that opens a token behind a flush is held until the old rows are read.
    assign wr_go   = (accept && plan.wr_en && !job_start) || (done && pw_reg);
    assign waddr   = busy_reg ? RAW'(0) : wr_idx[3 +: RAW];
    assign wr_bank = busy_reg ? 3'd0 : wr_idx[2:0];
    assign wdata   = busy_reg ? pw_byte_reg : ch;

    for (genvar b = 0; b < CHUNK_BYTES; b++)
    begin : g_bank
        mmt_ram #(
            .WIDTH(8),
            .DEPTH(ROWS)
        ) u_ram (
            .clk(clk),
            .we(wr_go && (wr_bank == 3'(b))),
            .waddr(waddr),
            .wdata(wdata),
            .re(issue),
            .raddr(iss_reg[RAW-1:0]),
            .rdata(rd_bank[b])
        );
    end

    always_comb
    begin
        rem = job_bc_reg - BCW'({rd_idx_reg, 3'b000});
        nb  = (rem > BCW'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : rem[3:0];
        for (int i = 0; i < CHUNK_BYTES; i++)
        begin
            chunk_val[8*i +: 8] = (4'(i) < nb) ? rd_bank[i] : 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            iss_reg       <= '0;
            rdv_reg       <= 1'b0;
            x_reg         <= 1'b0;
            pw_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_start)
            begin
                busy_reg <= 1'b1;
                iss_reg  <= '0;
                x_reg    <= x_in;
                pw_reg   <= plan.wr_en;
            end
            else
            begin
                if (done)
                begin
                    busy_reg <= 1'b0;
                    pw_reg   <= 1'b0;
                end
                if (issue)
                begin
                    iss_reg <= iss_reg + CNW'(1);
                end
                if (load_extra)
                begin
                    x_reg <= 1'b0;
                end
            end

            if (issue)
            begin
                rdv_reg <= 1'b1;
            end
            else if (load_chunk)
            begin
                rdv_reg <= 1'b0;
            end

            if (load_chunk || load_extra)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: job snapshot and output word.
    always_ff @(posedge clk)
    begin
        if (job_start)
        begin
            job_kind_reg  <= plan.fkind;
            job_line_reg  <= plan.line;
            job_col_reg   <= plan.fcol;
            job_trunc_reg <= plan.trunc;
            job_bc_reg    <= plan.flush ? fbytes : BCW'(0);
            job_nch_reg   <= nch_in;
            job_lim_reg   <= lim_in;
            x_kind_reg    <= plan.xkind;
            x_col_reg     <= plan.xcol;
            x_text_reg    <= plan.xtext;
            x_byte_reg    <= ch;
            pw_byte_reg   <= ch;
        end
        if (issue)
        begin
            rd_idx_reg <= iss_reg;
        end
        if (load_chunk)
        begin
            kind_reg   <= job_kind_reg;
            line_reg   <= job_line_reg;
            column_reg <= job_col_reg;
            chunk_reg  <= chunk_val;
            bytes_reg  <= nb;
            final_reg  <= (rd_idx_reg == (job_nch_reg - CNW'(1)));
            trunc_reg  <= job_trunc_reg;
            last_reg   <= chunk_last && !x_reg;
        end
        else if (load_extra)
        begin
            kind_reg   <= x_kind_reg;
            line_reg   <= job_line_reg;
            column_reg <= x_col_reg;
            chunk_reg  <= x_text_reg ? {56'd0, x_byte_reg} : 64'd0;
            bytes_reg  <= x_text_reg ? 4'd1 : 4'd0;
            final_reg  <= 1'b1;
            trunc_reg  <= 1'b0;
            last_reg   <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign line        = line_reg;
    assign column      = column_reg;
    assign text_chunk  = chunk_reg;
    assign chunk_bytes = bytes_reg;
    assign final_chunk = final_reg;
    assign truncated   = trunc_reg;
    assign last        = last_reg;

    `MMT_ASSERT(a_defer_row0, (job_start && plan.wr_en) |-> (wr_idx == '0))
    `MMT_NEVER(a_rw_clash, issue && wr_go)
    `MMT_ASSERT(a_rdv_busy, rdv_reg |-> busy_reg)
    `MMT_ASSERT(a_iss_bound, busy_reg |-> (iss_reg <= job_lim_reg))

endmodule

// ----- tb/math_markup_tokenizer_tb.sv -----
// Self-checking testbench for the math markup tokenizer: random text, token prediction, checks.
`timescale 1ns / 1ps

module math_markup_tokenizer_tb;
    import mmt_pkg::*;

    localparam int MAX_TEXT = 32;
    localparam int unsigned POS_LIMIT = 65535;
    localparam int LIMIT_CYCLES = 300000;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [63:0] chunk;
        logic [3:0]  nbytes;
        logic        fin;
        logic        trunc;
        logic        last;
    } token_t;

    class token_checker;
        token_t      pending_tokens[$];
        token_t      word_out[$];
        int          errors;
        bit          in_cmd;
        bit          skip_one;
        bit          tok_cut;
        logic [5:0]  cur_kind;
        logic [7:0]  tok_buf[MAX_TEXT];
        int unsigned tok_len;
        int unsigned cur_line;
        int unsigned cur_col;
        int unsigned start_col;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            in_cmd = 1'b0;
            skip_one = 1'b0;
            tok_cut = 1'b0;
            cur_kind = K_NONE;
            tok_len = 0;
            cur_line = 1;
            cur_col = 1;
            start_col = 1;
        endfunction

        function void emit(logic [5:0] k, int unsigned col, logic [63:0] chunk,
                           int unsigned n, bit fin, bit cut);
            token_t t;
            if (word_out.size() >= MAX_RESULTS)
                return;
            t.kind = k[4:0];
            t.line = cur_line[15:0];
            t.column = col[15:0];
            t.chunk = chunk;
            t.nbytes = n[3:0];
            t.fin = fin;
            t.trunc = cut;
            t.last = 1'b0;
            word_out.push_back(t);
        endfunction

        function void flush_tok(logic [5:0] k);
            int unsigned off;
            int unsigned n;
            logic [63:0] chunk;
            if (tok_len == 0)
                return;
            for (off = 0; off < tok_len; off += CHUNK_BYTES)
            begin
                n = (tok_len - off > CHUNK_BYTES) ? CHUNK_BYTES : tok_len - off;
                chunk = '0;
                for (int b = 0; b < n; b++)
                    chunk[8*b +: 8] = tok_buf[off + b];
                emit(k, start_col, chunk, n, off + n >= tok_len, tok_cut);
            end
            tok_len = 0;
            tok_cut = 1'b0;
        endfunction

        function void add_byte(logic [7:0] c);
            if (tok_len < MAX_TEXT)
            begin
                tok_buf[tok_len] = c;
                tok_len++;
            end
            else
                tok_cut = 1'b1;
        endfunction

        function void bump_col(int unsigned n);
            cur_col = (cur_col + n > POS_LIMIT) ? POS_LIMIT : cur_col + n;
        endfunction

        // Work out the tokens that one accepted input word releases.
        function void accept_word(logic o, logic [7:0] c, logic [7:0] nc, logic hn);
            logic [5:0] prev;
            logic [5:0] kin;
            word_out.delete();
            prev = cur_kind;
            if (o == OP_END)
            begin
                flush_tok(in_cmd ? K_COMMAND : cur_kind);
                emit(K_EOF, cur_col, '0, 0, 1'b1, 1'b0);
                restart();
            end
            else if (skip_one)
                skip_one = 1'b0;
            else if (in_cmd && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")))
            begin
                add_byte(c);
                bump_col(1);
            end
            else
            begin
                if (in_cmd)
                begin
                    flush_tok(K_COMMAND);
                    in_cmd = 1'b0;
                    cur_kind = K_NONE;
                    prev = K_NONE;
                end
                if (c == CH_DOT && prev == K_NUMBER && hn && nc >= "0" && nc <= "9")
                begin
                    add_byte(c);
                    cur_kind = K_DECIMAL;
                    bump_col(1);
                end
                else if (c == CH_BSLASH)
                begin
                    flush_tok(cur_kind);
                    if (hn && nc == CH_BSLASH)
                    begin
                        emit(K_DBL, cur_col, '0, 0, 1'b1, 1'b0);
                        skip_one = 1'b1;
                        bump_col(2);
                        cur_kind = K_NONE;
                    end
                    else
                    begin
                        in_cmd = 1'b1;
                        cur_kind = K_COMMAND;
                        start_col = cur_col;
                        bump_col(1);
                    end
                end
                else if (c == CH_SPACE || c == CH_TAB)
                begin
                    flush_tok(cur_kind);
                    cur_kind = K_NONE;
                    bump_col(1);
                end
                else if (c == CH_NL)
                begin
                    flush_tok(cur_kind);
                    cur_kind = K_NONE;
                    if (cur_line < POS_LIMIT)
                        cur_line++;
                    cur_col = 1;
                end
                else
                begin
                    if (c >= "0" && c <= "9")
                        kin = (prev == K_DECIMAL) ? K_DECIMAL : K_NUMBER;
                    else if (c == CH_DOT)
                        kin = K_DOT;
                    else
                        case (c)
                            "=":     kin = K_EQUALS;
                            "(":     kin = K_LPAREN;
                            ")":     kin = K_RPAREN;
                            "{":     kin = K_LBRACE;
                            "+":     kin = K_PLUS;
                            "-":     kin = K_MINUS;
                            "*":     kin = K_STAR;
                            "/":     kin = K_SLASH;
                            ",":     kin = K_COMMA;
                            "^":     kin = K_CARET;
                            ":":     kin = K_COLON;
                            ";":     kin = K_SEMICOLON;
                            "|":     kin = K_PIPE;
                            "<":     kin = K_LESS;
                            ">":     kin = K_GREATER;
                            "'":     kin = K_PRIME;
                            "$":     kin = K_DOLLAR;
                            "%":     kin = K_PERCENT;
                            "~":     kin = K_TILDE;
                            "#":     kin = K_HASH;
                            "_":     kin = K_UNDERSCR;
                            "[":     kin = K_LBRACK;
                            "]":     kin = K_RBRACK;
                            "}":     kin = K_RBRACE;
                            "&":     kin = K_AMP;
                            default: kin = K_IDENT;
                        endcase
                    cur_kind = kin;
                    if (kin != prev)
                        flush_tok(prev);
                    if (tok_len == 0)
                        start_col = cur_col;
                    add_byte(c);
                    bump_col(1);
                    // punctuation never accumulates
                    if (kin != K_IDENT && kin != K_NUMBER && kin != K_DECIMAL)
                    begin
                        flush_tok(kin);
                        cur_kind = K_NONE;
                    end
                end
            end
            if (word_out.size() > 0)
                word_out[word_out.size() - 1].last = 1'b1;
            foreach (word_out[i])
                pending_tokens.push_back(word_out[i]);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void match_token(token_t got);
            token_t want;
            if (pending_tokens.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected token: expected none, got kind %0d text %0h",
                         $time, got.kind, got.chunk);
                return;
            end
            want = pending_tokens.pop_front();
            check_field("kind", 64'(want.kind), 64'(got.kind));
            check_field("line", 64'(want.line), 64'(got.line));
            check_field("column", 64'(want.column), 64'(got.column));
            check_field("text_chunk", want.chunk, got.chunk);
            check_field("chunk_bytes", 64'(want.nbytes), 64'(got.nbytes));
            check_field("final_chunk", 64'(want.fin), 64'(got.fin));
            check_field("truncated", 64'(want.trunc), 64'(got.trunc));
            check_field("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = 1'b0;
    logic [7:0]  ch = 8'h00;
    logic [7:0]  next_ch = 8'h00;
    logic        has_next = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [63:0] text_chunk;
    logic [3:0]  chunk_bytes;
    logic        final_chunk;
    logic        truncated;
    logic        last;

    token_checker sb;
    int           send_gap_pct = 17;
    int           recv_stall_pct = 81;
    int           words_sent = 0;
    int           cycles = 0;
    string        punct_set = "=(){+-*/,^:;|<>'$%~#_[]}&.";

    math_markup_tokenizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .ch          (ch),
        .next_ch     (next_ch),
        .has_next    (has_next),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .line        (line),
        .column      (column),
        .text_chunk  (text_chunk),
        .chunk_bytes (chunk_bytes),
        .final_chunk (final_chunk),
        .truncated   (truncated),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Check results before noting the word taken at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.match_token(token_t'({kind, line, column, text_chunk, chunk_bytes,
                                         final_chunk, truncated, last}));
            if (in_valid && !in_stall)
                sb.accept_word(op, ch, next_ch, has_next);
        end
    end

    task automatic send_word(input logic o, input logic [7:0] c, input logic [7:0] nc,
                             input logic hn);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        ch <= c;
        next_ch <= nc;
        has_next <= hn;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    // Stream text with true lookahead; the last byte has none.
    task automatic send_document(input logic [7:0] doc[$], input bit close);
        for (int i = 0; i < doc.size(); i++)
        begin
            if (i + 1 < doc.size())
                send_word(OP_TEXT, doc[i], doc[i + 1], 1'b1);
            else
                send_word(OP_TEXT, doc[i], 8'($urandom_range(255)), 1'b0);
        end
        if (close)
            send_word(OP_END, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(1) ? 8'(8'h61 + $urandom_range(25))
                                 : 8'(8'h41 + $urandom_range(25));
    endfunction

    function automatic void add_piece(ref logic [7:0] doc[$]);
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(99);
        n = ($urandom_range(11) == 0) ? $urandom_range(33, 38) : $urandom_range(1, 5);
        if (pick < 22)
        begin
            repeat (n) doc.push_back(rand_letter());
        end
        else if (pick < 36)
        begin
            repeat (n) doc.push_back(8'(8'h30 + $urandom_range(9)));
            if ($urandom_range(1))
            begin
                doc.push_back(CH_DOT);
                repeat ($urandom_range(0, 3)) doc.push_back(8'(8'h30 + $urandom_range(9)));
            end
        end
        else if (pick < 56)
            doc.push_back(punct_set[$urandom_range(punct_set.len() - 1)]);
        else if (pick < 68)
        begin
            doc.push_back(CH_BSLASH);
            repeat (n) doc.push_back(rand_letter());
        end
        else if (pick < 73)
        begin
            doc.push_back(CH_BSLASH);
            doc.push_back(CH_BSLASH);
        end
        else if (pick < 76)
            doc.push_back(CH_BSLASH);
        else if (pick < 92)
        begin
            case ($urandom_range(2))
                0:       doc.push_back(CH_SPACE);
                1:       doc.push_back(CH_TAB);
                default: doc.push_back(CH_NL);
            endcase
        end
        else if (pick < 95)
            doc.push_back(8'h00);
        else
            doc.push_back(8'($urandom_range(255)));
    endfunction

    initial
    begin
        logic [7:0]  doc[$];
        int unsigned target;
        string       intro;

        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // double backslash whose skipped word is the end of text
        send_word(OP_TEXT, CH_BSLASH, CH_BSLASH, 1'b1);
        send_word(OP_END, 8'hFF, 8'hFF, 1'b1);

        intro = "ab3.14+\\pi\\\\y\n\\ 7.x";
        foreach (intro[i])
            doc.push_back(intro[i]);
        doc.push_back(8'h00);
        doc.push_back(8'hFF);
        send_document(doc, 1'b0);
        send_word(OP_END, 8'h00, 8'h00, 1'b0);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_gap_pct = 17;
                    recv_stall_pct = 81;
                end
                1:
                begin
                    send_gap_pct = 81;
                    recv_stall_pct = 17;
                end
                default:
                begin
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            while (words_sent < 25 + 62 * (phase + 1))
            begin
                if ($urandom_range(99) < 12)
                    send_word($urandom_range(7) == 0, 8'($urandom_range(255)),
                              8'($urandom_range(255)), 1'($urandom_range(1)));
                else
                begin
                    doc.delete();
                    target = $urandom_range(4, 22);
                    while (doc.size() < target)
                        add_piece(doc);
                    send_document(doc, $urandom_range(4) != 0);
                end
            end
        end

        in_valid <= 1'b0;
        while (sb.pending_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending_tokens.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/mmt_pkg.sv
src/mmt_ram.sv
src/mmt_lex.sv
src/math_markup_tokenizer.sv
tb/math_markup_tokenizer_tb.sv
